[sv/lawstf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_pkg
// shared widths, register codes, mask coefficients and datapath types for the
// laws texture filter bank
// ----------------------------------------------------------------------------
package lawstf_pkg;

    // data widths
    localparam int PIX_W   = 8;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 9;
    localparam int RESP0_W = 16;
    localparam int RESP_W  = 18;
    localparam int SUM_W   = 13;
    localparam int NMASK   = 9;
    localparam int NTAP    = 9;

    // configuration port
    localparam int FW_W       = 10;
    localparam int FH_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FW_RESET = FW_W'(512);
    localparam logic [FH_W-1:0] FH_RESET = FH_W'(512);

    localparam int MAX_WIDTH_DEF = 512;
    localparam int MIN_DIM       = 3;
    localparam int MAX_HEIGHT    = 4096;

    // mask coefficients, taps in raster order (top-left first)
    typedef logic signed [3:0] coef_t;

    localparam coef_t MASK_COEF [NMASK][NTAP] = '{
        '{ 1,  2,  1,   2,  4,  2,   1,  2,  1},
        '{ 1,  0, -1,   2,  0, -2,   1,  0, -1},
        '{-1,  2, -1,  -2,  4, -2,  -1,  2, -1},
        '{-1, -2, -1,   0,  0,  0,   1,  2,  1},
        '{ 1,  0, -1,   0,  0,  0,  -1,  0,  1},
        '{-1,  2, -1,   0,  0,  0,   1, -2,  1},
        '{-1, -2, -1,   2,  4,  2,  -1, -2, -1},
        '{-1,  0,  1,   2,  0, -2,  -1,  0,  1},
        '{ 1, -2,  1,  -2,  4, -2,   1, -2,  1}
    };

    // normalisers
    localparam int NORM_X4  = 4;
    localparam int NORM_X12 = 12;
    localparam int NORM_X36 = 36;

    localparam int NORM_TAB [NMASK] = '{
        NORM_X36, NORM_X12, NORM_X12, NORM_X12, NORM_X4,
        NORM_X4,  NORM_X12, NORM_X4,  NORM_X4
    };

    // s*256/n = (s*64)/(n/4); rounding offset n/2 shrinks to (n/2)>>2
    localparam int PRE_SHIFT = 6;
    localparam int RND_X12   = (NORM_X12 / 2) / 4;
    localparam int RND_X36   = (NORM_X36 / 2) / 4;

    // reciprocals for /3 and /9, exact for quotients of 19-bit values
    localparam int RECIP_W      = 19;
    localparam int RECIP3       = 349526;
    localparam int RECIP3_SHIFT = 20;
    localparam int RECIP9       = 233017;
    localparam int RECIP9_SHIFT = 21;

    // frame control from the register file to the window stage
    typedef struct packed {
        logic             restart;
        logic [ROW_W-1:0] h_last;
    } frame_ctl_t;

    // one emission: selected 3x3 taps and the centre position
    typedef struct packed {
        logic [NTAP-1:0][PIX_W-1:0] taps;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       last;
    } emit_t;

    // raw mask sums and the centre position
    typedef struct packed {
        logic [NMASK-1:0][SUM_W-1:0] sum;
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic                        last;
    } sums_t;

endpackage

`default_nettype wire

[sv/lawstf_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lawstf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/lawstf_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_window
// raster position, row stores, 3x3 window and the emission scheduler
// ----------------------------------------------------------------------------
module lawstf_window #(
    parameter int MAX_WIDTH = lawstf_pkg::MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lawstf_pkg::frame_ctl_t      ctl,
    input  logic [CW-1:0]               w_last,
    input  logic                        pixel_valid,
    output logic                        pixel_ready,
    input  logic [lawstf_pkg::PIX_W-1:0] pixel,
    output logic                        em_valid,
    input  logic                        em_ready,
    output lawstf_pkg::emit_t           em
);

    import lawstf_pkg::*;

    localparam int XW = (CW > COL_W) ? CW : COL_W;

    // raster position of the next pixel
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;

    // stage 1: accepted pixel waiting for row store data
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg, s1_pix_next;
    logic [ROW_W-1:0] s1_row_reg, s1_row_next;
    logic [CW-1:0]    s1_col_reg, s1_col_next;

    // window and pending emissions
    logic [PIX_W-1:0] win_reg [NTAP];
    logic [PIX_W-1:0] win_next [NTAP];
    logic [3:0]       mask_reg, mask_next;
    logic [ROW_W-1:0] s2_row_reg, s2_row_next;
    logic [CW-1:0]    s2_col_reg, s2_col_next;

    logic [2*PIX_W-1:0] ram_rd;
    logic [2*PIX_W-1:0] ram_wr;
    logic [PIX_W-1:0]   older, newer, top, mid;
    logic [PIX_W-1:0]   vin [3];

    logic       accept, em_fire, s2_single, s2_free, s1_adv;
    logic       first_row, second_row, last_col, last_row, col_zero;
    logic [3:0] sel;
    logic       rows_last, cols_edge;
    logic [CW-1:0] em_colv;
    logic [XW-1:0] em_col_ext;

    assign accept      = pixel_valid && pixel_ready;
    assign em_valid    = (mask_reg != 4'd0);
    assign em_fire     = em_valid && em_ready;
    assign s2_single   = ((mask_reg & (mask_reg - 4'd1)) == 4'd0);
    assign s2_free     = !em_valid || (em_fire && s2_single);
    assign s1_adv      = s1_valid_reg && s2_free;
    assign pixel_ready = !s1_valid_reg || s1_adv;

    assign first_row  = (s1_row_reg == '0);
    assign second_row = (s1_row_reg == ROW_W'(1));
    assign last_col   = (s1_col_reg == w_last);
    assign last_row   = (s1_row_reg == ctl.h_last);
    assign col_zero   = (s1_col_reg == '0);

    // row store entry holds {older, newer}
    assign older  = ram_rd[2*PIX_W-1:PIX_W];
    assign newer  = ram_rd[PIX_W-1:0];
    assign top    = first_row ? s1_pix_reg : (second_row ? newer : older);
    assign mid    = first_row ? s1_pix_reg : newer;
    assign ram_wr = {newer, s1_pix_reg};
    assign vin[0] = top;
    assign vin[1] = mid;
    assign vin[2] = s1_pix_reg;

    lawstf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    // lowest pending emission goes first
    assign sel[0]    = mask_reg[0];
    assign sel[1]    = mask_reg[1] & ~mask_reg[0];
    assign sel[2]    = mask_reg[2] & ~(|mask_reg[1:0]);
    assign sel[3]    = mask_reg[3] & ~(|mask_reg[2:0]);
    assign rows_last = sel[2] | sel[3];
    assign cols_edge = sel[1] | sel[3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (rows_last)
                begin
                    if (cols_edge)
                        em.taps[i*3+j] = win_reg[((i == 0) ? 1 : 2)*3 + ((j == 0) ? 1 : 2)];
                    else
                        em.taps[i*3+j] = win_reg[((i == 0) ? 1 : 2)*3 + j];
                end
                else
                begin
                    if (cols_edge)
                        em.taps[i*3+j] = win_reg[i*3 + ((j == 0) ? 1 : 2)];
                    else
                        em.taps[i*3+j] = win_reg[i*3 + j];
                end
            end
        end
    end

    assign em.row     = (sel[0] | sel[1]) ? (s2_row_reg - ROW_W'(1)) : s2_row_reg;
    assign em_colv    = (sel[0] | sel[2]) ? (s2_col_reg - CW'(1)) : s2_col_reg;
    assign em_col_ext = XW'(em_colv);
    assign em.col     = em_col_ext[COL_W-1:0];
    assign em.last    = ((mask_reg & ~sel) == 4'd0);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (ctl.restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == w_last)
            begin
                col_next = '0;
                row_next = (row_reg == ctl.h_last) ? '0 : (row_reg + ROW_W'(1));
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s1_pix_next   = accept ? pixel   : s1_pix_reg;
        s1_row_next   = accept ? row_reg : s1_row_reg;
        s1_col_next   = accept ? col_reg : s1_col_reg;

        for (int k = 0; k < NTAP; k++)
        begin
            win_next[k] = win_reg[k];
        end
        mask_next   = mask_reg;
        s2_row_next = s2_row_reg;
        s2_col_next = s2_col_reg;

        if (s1_adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (col_zero)
                begin
                    win_next[i*3]   = vin[i];
                    win_next[i*3+1] = vin[i];
                end
                else
                begin
                    win_next[i*3]   = win_reg[i*3+1];
                    win_next[i*3+1] = win_reg[i*3+2];
                end
                win_next[i*3+2] = vin[i];
            end
            mask_next[0] = !first_row && !col_zero;
            mask_next[1] = !first_row && last_col;
            mask_next[2] = last_row && !col_zero;
            mask_next[3] = last_row && last_col;
            s2_row_next  = s1_row_reg;
            s2_col_next  = s1_col_reg;
        end
        else if (em_fire)
        begin
            mask_next = mask_reg & ~sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            mask_reg     <= 4'd0;
            for (int k = 0; k < NTAP; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            mask_reg     <= mask_next;
            for (int k = 0; k < NTAP; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg <= s1_pix_next;
        s1_row_reg <= s1_row_next;
        s1_col_reg <= s1_col_next;
        s2_row_reg <= s2_row_next;
        s2_col_reg <= s2_col_next;
    end

endmodule

`default_nettype wire

[sv/lawstf_mask_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_mask_sum
// nine constant-coefficient 3x3 mask sums, registered
// ----------------------------------------------------------------------------
module lawstf_mask_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              em_valid,
    output logic              em_ready,
    input  lawstf_pkg::emit_t em,
    output logic              sm_valid,
    input  logic              sm_ready,
    output lawstf_pkg::sums_t sm
);

    import lawstf_pkg::*;

    logic  sm_valid_reg, sm_valid_next;
    sums_t sm_reg, sm_next;

    assign em_ready = !sm_valid_reg || sm_ready;
    assign sm_valid = sm_valid_reg;
    assign sm       = sm_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] coef;
        logic signed [SUM_W-1:0] pix;
        sm_valid_next = sm_valid_reg;
        if (em_ready)
        begin
            sm_valid_next = em_valid;
        end
        sm_next      = sm_reg;
        sm_next.row  = em.row;
        sm_next.col  = em.col;
        sm_next.last = em.last;
        for (int m = 0; m < NMASK; m++)
        begin
            acc = '0;
            for (int k = 0; k < NTAP; k++)
            begin
                coef = SUM_W'(MASK_COEF[m][k]);
                pix  = SUM_W'(em.taps[k]);
                acc  = acc + coef * pix;
            end
            sm_next.sum[m] = acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_valid_reg <= 1'b0;
        end
        else
        begin
            sm_valid_reg <= sm_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (em_ready && em_valid)
        begin
            sm_reg <= sm_next;
        end
    end

endmodule

`default_nettype wire

[sv/lawstf_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_scale
// divides each sum by its normaliser with rounding, saturates, output register
// ----------------------------------------------------------------------------
module lawstf_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sm_valid,
    output logic                              sm_ready,
    input  lawstf_pkg::sums_t                 sm,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lawstf_pkg::RESP0_W-1:0]    resp_l3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_l3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_l3s3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_e3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_e3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_e3s3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_s3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_s3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0] resp_s3s3,
    output logic [lawstf_pkg::ROW_W-1:0]      out_row,
    output logic [lawstf_pkg::COL_W-1:0]      out_col,
    output logic                              last_of_run
);

    import lawstf_pkg::*;

    localparam int Y_W    = SUM_W + PRE_SHIFT;
    localparam int PROD_W = Y_W + RECIP_W;
    localparam int Q_W    = Y_W;
    localparam int V_W    = Q_W + 1;

    logic             out_valid_reg, out_valid_next;
    logic [RESP_W-1:0] res_reg [NMASK];
    logic [RESP_W-1:0] res_next [NMASK];
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             last_reg;
    logic             load;

    assign sm_ready = !out_valid_reg || out_ready;
    assign load     = sm_ready && sm_valid;

    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        logic [SUM_W-1:0]        mag;
        logic [Y_W-1:0]          y;
        logic [PROD_W-1:0]       prod;
        logic [Q_W-1:0]          q;
        logic signed [V_W-1:0]   v;
        for (int m = 0; m < NMASK; m++)
        begin
            s    = sm.sum[m];
            mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
            y    = Y_W'(mag) << PRE_SHIFT;
            prod = '0;
            case (NORM_TAB[m])
                NORM_X4:
                begin
                    q = Q_W'(y);
                end
                NORM_X12:
                begin
                    prod = PROD_W'(y + Y_W'(RND_X12)) * PROD_W'(RECIP3);
                    q    = Q_W'(prod >> RECIP3_SHIFT);
                end
                NORM_X36:
                begin
                    prod = PROD_W'(y + Y_W'(RND_X36)) * PROD_W'(RECIP9);
                    q    = Q_W'(prod >> RECIP9_SHIFT);
                end
                default:
                begin
                    q = '0;
                end
            endcase
            v = s[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            if (m == 0)
            begin
                if (v < 0)
                    res_next[m] = '0;
                else if (v > 65535)
                    res_next[m] = RESP_W'(65535);
                else
                    res_next[m] = RESP_W'(v);
            end
            else
            begin
                if (v < -131072)
                    res_next[m] = RESP_W'(-131072);
                else if (v > 131071)
                    res_next[m] = RESP_W'(131071);
                else
                    res_next[m] = RESP_W'(v);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sm_ready)
        begin
            out_valid_next = sm_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int m = 0; m < NMASK; m++)
            begin
                res_reg[m] <= res_next[m];
            end
            row_reg  <= sm.row;
            col_reg  <= sm.col;
            last_reg <= sm.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign resp_l3l3   = res_reg[0][RESP0_W-1:0];
    assign resp_l3e3   = $signed(res_reg[1]);
    assign resp_l3s3   = $signed(res_reg[2]);
    assign resp_e3l3   = $signed(res_reg[3]);
    assign resp_e3e3   = $signed(res_reg[4]);
    assign resp_e3s3   = $signed(res_reg[5]);
    assign resp_s3l3   = $signed(res_reg[6]);
    assign resp_s3e3   = $signed(res_reg[7]);
    assign resp_s3s3   = $signed(res_reg[8]);
    assign out_row     = row_reg;
    assign out_col     = col_reg;
    assign last_of_run = last_reg;

endmodule

`default_nettype wire

[sv/laws_texture_filter_bank.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one pixel per cycle while results are taken; a pixel causing k results holds
//   pixel_ready low until all but its last result are taken (k is 2 at the last column or
//   on the last row, 4 at the last pixel); the single shared result path (mask sums, then
//   scaling) delivers one result word a cycle while out_ready is high
// reset: clears all handshake and position state, frame size returns to 512 x 512;
//   row stores are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// laws_texture_filter_bank
// streaming bank of the nine laws 3x3 texture masks with replicated borders
// ----------------------------------------------------------------------------
module laws_texture_filter_bank #(
    parameter int MAX_WIDTH = lawstf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [lawstf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lawstf_pkg::CFG_DATA_W-1:0]     cfg_data,
    // pixel stream
    input  logic                                  pixel_valid,
    output logic                                  pixel_ready,
    input  logic [lawstf_pkg::PIX_W-1:0]          pixel,
    // result stream
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [lawstf_pkg::RESP0_W-1:0]        resp_l3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_l3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_l3s3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3s3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3l3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3e3,
    output logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3s3,
    output logic [lawstf_pkg::ROW_W-1:0]          out_row,
    output logic [lawstf_pkg::COL_W-1:0]          out_col,
    output logic                                  last_of_run
);

    import lawstf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    // wide enough for the width register and for MAX_WIDTH itself
    localparam int WW = (CW + 1 > FW_W) ? CW + 1 : FW_W;

    // configuration registers
    logic [FW_W-1:0] frame_width_reg, frame_width_next;
    logic [FH_W-1:0] frame_height_reg, frame_height_next;

    logic [WW-1:0]   fw_ext, w_eff;
    logic [CW-1:0]   w_last;
    logic [FH_W-1:0] h_eff;
    frame_ctl_t      ctl;

    // inter-stage handshakes
    logic    em_valid, em_ready;
    emit_t   em;
    logic    sm_valid, sm_ready;
    sums_t   sm;

    // register writes; a write to a known register restarts the raster position
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    assign ctl.restart = cfg_wr_en && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT});

    // out-of-range sizes clamp to the nearest legal size
    assign fw_ext = WW'(frame_width_reg);

    always_comb
    begin
        if (fw_ext < WW'(MIN_DIM))
            w_eff = WW'(MIN_DIM);
        else if (fw_ext > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext;

        if (frame_height_reg < FH_W'(MIN_DIM))
            h_eff = FH_W'(MIN_DIM);
        else if (frame_height_reg > FH_W'(MAX_HEIGHT))
            h_eff = FH_W'(MAX_HEIGHT);
        else
            h_eff = frame_height_reg;
    end

    assign w_last     = CW'(w_eff - WW'(1));
    assign ctl.h_last = ROW_W'(h_eff - FH_W'(1));

    // row stores, window and emission scheduler
    lawstf_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .w_last      (w_last),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .em_valid    (em_valid),
        .em_ready    (em_ready),
        .em          (em)
    );

    // mask sums, one register stage
    lawstf_mask_sum u_mask_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .em_valid (em_valid),
        .em_ready (em_ready),
        .em       (em),
        .sm_valid (sm_valid),
        .sm_ready (sm_ready),
        .sm       (sm)
    );

    // normalise, round, saturate into the output register
    lawstf_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .sm_valid    (sm_valid),
        .sm_ready    (sm_ready),
        .sm          (sm),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .resp_l3l3   (resp_l3l3),
        .resp_l3e3   (resp_l3e3),
        .resp_l3s3   (resp_l3s3),
        .resp_e3l3   (resp_e3l3),
        .resp_e3e3   (resp_e3e3),
        .resp_e3s3   (resp_e3s3),
        .resp_s3l3   (resp_s3l3),
        .resp_s3e3   (resp_s3e3),
        .resp_s3s3   (resp_s3s3),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run)
    );

endmodule

`default_nettype wire

[sv/lawstf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lawstf_checker
// port-level checks on the result stream of the filter bank
// ----------------------------------------------------------------------------
module lawstf_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [lawstf_pkg::RESP0_W-1:0]        resp_l3l3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_l3e3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_l3s3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3l3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3e3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_e3s3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3l3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3e3,
    input logic signed [lawstf_pkg::RESP_W-1:0]  resp_s3s3,
    input logic [lawstf_pkg::ROW_W-1:0]          out_row,
    input logic [lawstf_pkg::COL_W-1:0]          out_col,
    input logic                                  last_of_run
);

    // nothing comes out in the first cycle after reset
    a_reset_quiet: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result word valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(resp_l3l3) && $stable(resp_l3e3) && $stable(resp_l3s3)
            && $stable(resp_e3l3) && $stable(resp_e3e3) && $stable(resp_e3s3)
            && $stable(resp_s3l3) && $stable(resp_s3e3) && $stable(resp_s3s3)
            && $stable(last_of_run))
        else $error("stalled result word changed");

    // results of one pixel leave back to back
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("gap inside a run of results");

    // within a run the centre moves by at most one row and one column
    a_run_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
            (out_row == $past(out_row) || out_row == $past(out_row) + 12'd1) &&
            (out_col == $past(out_col) || out_col == $past(out_col) + 9'd1 ||
             out_col == $past(out_col) - 9'd1))
        else $error("run centre jumped");

endmodule

bind laws_texture_filter_bank lawstf_checker u_checker (.*);

`default_nettype wire
